[rtl/core/ctd_pkg.sv]
package ctd_pkg;

   localparam int SIZE_BITS = 32;
   localparam int LEN_BITS  = 32;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [4:0] HEX_RADIX    = 5'd16;

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_SIZE_LINE,
      PH_DATA,
      PH_DATA_LINE,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.is_hex = 1'b1;
      d.value  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         d.value = c[3:0] + 4'd9;
      end else begin
         d.is_hex = 1'b0;
      end
      return d;
   endfunction

endpackage

[rtl/core/ctd_req_if.sv]
interface ctd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

[rtl/core/ctd_rsp_if.sv]
interface ctd_rsp_if;
   logic        valid;
   logic        ready;
   logic        data_valid;
   logic [7:0]  out_byte;
   logic        message_end;
   logic        status;
   logic [31:0] decoded_length;

   modport source (output valid, output data_valid, output out_byte, output message_end,
                   output status, output decoded_length, input ready);
   modport sink   (input valid, input data_valid, input out_byte, input message_end,
                   input status, input decoded_length, output ready);
endinterface

[rtl/core/chunked_transfer_decoder_top.sv]
// Chunked transfer decoder. Feed the raw chunked message one byte per beat on
// req_ch, with last_byte set on its final byte; rsp_ch returns one beat per
// payload byte and one beat for the final byte, which carries message_end, the
// status (0 well formed, 1 malformed) and the running payload length. Bytes of
// size lines, line tails and anything after the zero-size chunk produce no
// beat. Each byte is decoded in the cycle it is accepted and its result lands
// in a single output register, so the block takes one byte every cycle; the
// only thing that holds req_ch.ready low is a result in that register that
// rsp_ch has not yet taken. Chunk sizes are hex, either case, and wrap modulo
// 2^SIZE_BITS. State returns to reset after every final byte.
module chunked_transfer_decoder_top (
   input  logic         clock,
   input  logic         reset,
   ctd_req_if.sink      req_ch,
   ctd_rsp_if.source    rsp_ch
);
   import ctd_pkg::*;

   // decoder state
   phase_type              phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   chunk_count_ff, chunk_count_in;
   logic                   saw_digit_ff, saw_digit_in;
   logic [LEN_BITS-1:0]    payload_total_ff, payload_total_in;

   // output register
   logic                   rsp_valid_ff;
   logic                   data_valid_ff;
   logic [7:0]             out_byte_ff;
   logic                   message_end_ff;
   logic                   status_ff;
   logic [LEN_BITS-1:0]    decoded_length_ff;

   logic                   accept;
   logic                   emit;
   logic                   has_result;
   hex_digit_type          digit;

   // Take a new byte whenever the output register is empty or draining.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign digit        = hex_decode(req_ch.in_byte);

   // Next state for the byte on the input.
   always_comb begin
      phase_in         = phase_ff;
      chunk_count_in   = chunk_count_ff;
      saw_digit_in     = saw_digit_ff;
      payload_total_in = payload_total_ff;
      case (phase_ff)
         PH_SIZE: begin
            if (digit.is_hex) begin
               // Shift in one hex digit; the top nibble falls off.
               chunk_count_in = {chunk_count_ff[SIZE_BITS-5:0], digit.value};
               saw_digit_in   = 1'b1;
            end else if (!saw_digit_ff) begin
               phase_in = PH_ERROR;
            end else if (req_ch.in_byte == NEWLINE_BYTE) begin
               phase_in = (chunk_count_ff == '0) ? PH_DONE : PH_DATA;
            end else begin
               phase_in = PH_SIZE_LINE;
            end
         end
         PH_SIZE_LINE: begin
            if (req_ch.in_byte == NEWLINE_BYTE) begin
               phase_in = (chunk_count_ff == '0) ? PH_DONE : PH_DATA;
            end
         end
         PH_DATA: begin
            payload_total_in = payload_total_ff + LEN_BITS'(1);
            chunk_count_in   = chunk_count_ff - SIZE_BITS'(1);
            if (chunk_count_ff == SIZE_BITS'(1)) begin
               phase_in = PH_DATA_LINE;
            end
         end
         PH_DATA_LINE: begin
            if (req_ch.in_byte == NEWLINE_BYTE) begin
               phase_in       = PH_SIZE;
               chunk_count_in = '0;
               saw_digit_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result for the byte on the input.
   always_comb begin
      emit       = (phase_ff == PH_DATA);
      has_result = emit || req_ch.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SIZE;
         chunk_count_ff   <= '0;
         saw_digit_ff     <= 1'b0;
         payload_total_ff <= '0;
      end else if (accept) begin
         if (req_ch.last_byte) begin
            // Drop all message state so the next byte opens a new message.
            phase_ff         <= PH_SIZE;
            chunk_count_ff   <= '0;
            saw_digit_ff     <= 1'b0;
            payload_total_ff <= '0;
         end else begin
            phase_ff         <= phase_in;
            chunk_count_ff   <= chunk_count_in;
            saw_digit_ff     <= saw_digit_in;
            payload_total_ff <= payload_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result beat; hold it while rsp_ch stalls.
   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         data_valid_ff     <= emit;
         out_byte_ff       <= emit ? req_ch.in_byte : 8'd0;
         message_end_ff    <= req_ch.last_byte;
         status_ff         <= req_ch.last_byte && (phase_in != PH_DONE);
         decoded_length_ff <= payload_total_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.data_valid     = data_valid_ff;
   assign rsp_ch.out_byte       = out_byte_ff;
   assign rsp_ch.message_end    = message_end_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.decoded_length = decoded_length_ff;

endmodule
